[design/smbc_pkg.sv]
// package for the source mask balance and contrast unit
// holds widths, pipeline depths, register indexes and the log2/exp2 tables
// no dependencies
`timescale 1ns / 1ps

package smbc_pkg;

   // table resolution of the power stage
   localparam int LOG_TABLE_BITS = 8;
   localparam int LOG_SIZE       = 1 << LOG_TABLE_BITS;

   // lane count and datapath widths
   localparam int LANES      = 4;
   localparam int MASK_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int CONTRAST_W = 9;
   localparam int SCALED_W   = 31;
   localparam int DIV_W      = 33;
   localparam int Q_W        = 16;
   localparam int GQ_W       = 13;
   localparam int NEG_W      = 20;
   localparam int EXP_W      = 25;
   localparam int EX_W       = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // pipeline depths
   localparam int DIV_STAGES = Q_W;
   localparam int POW_STAGES = 4;
   localparam int DLY_STAGES = DIV_STAGES + POW_STAGES;
   localparam int LATENCY    = 2 + DIV_STAGES + 1 + DIV_STAGES + POW_STAGES + 1;

   localparam logic [Q_W-1:0]  ONE_Q15  = 16'h8000;
   localparam logic [GQ_W-1:0] GQ_UNITY = 13'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOCAL_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASS_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRUM_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OTHER_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTRAST   = 3'd4;

   typedef logic [15:0]     lg_table_type [LOG_SIZE];
   typedef logic [EX_W-1:0] ex_table_type [LOG_SIZE];

   // integer square root, elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      logic        found;
      x = xin;
      r = '0;
      b = 64'd1 << 62;
      found = 1'b0;
      for (int i = 0; i < 32; i++) begin
         if (!found && b > x) begin
            b = b >> 2;
         end else begin
            found = 1'b1;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // floor(2^16 * log2(1 + idx/2^L)) by repeated squaring
   function automatic lg_table_type build_lg_table();
      lg_table_type tbl;
      logic [63:0]  x;
      logic [63:0]  lg;
      for (int idx = 0; idx < LOG_SIZE; idx++) begin
         x  = 64'(LOG_SIZE + idx) << (30 - LOG_TABLE_BITS);
         lg = '0;
         for (int i = 15; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
               x  = x >> 1;
               lg = lg | (64'd1 << i);
            end
         end
         tbl[idx] = lg[15:0];
      end
      return tbl;
   endfunction

   // 2^(-j/2^L) in q1.30 as a product of square-root chain factors
   function automatic ex_table_type build_ex_table();
      ex_table_type tbl;
      logic [63:0]  res;
      logic [63:0]  r;
      for (int j = 0; j < LOG_SIZE; j++) begin
         res = 64'd1 << 30;
         r   = 64'd1 << 29;
         for (int m = 1; m <= LOG_TABLE_BITS; m++) begin
            r = isqrt64(r << 30);
            if (((j >> (LOG_TABLE_BITS - m)) & 1) != 0) begin
               res = (res * r) >> 30;
            end
         end
         tbl[j] = res[EX_W-1:0];
      end
      return tbl;
   endfunction

   localparam lg_table_type LG_TABLE = build_lg_table();
   localparam ex_table_type EX_TABLE = build_ex_table();

endpackage

[design/source_mask_balance_contrast_unit.sv]
// top level of the source mask balance and contrast unit
// lanes of smbc_div and smbc_pow with the sum and min/max merge; depends on smbc_pkg
//
//   channel   handshake             beat
//   req       start / busy          four signed q3.12 masks
//   rsp       rsp_valid (strobe)    four q1.15 masks
//   csr       csr_valid / csr_ready register index and data
//
// one bin per cycle; every bin leaves in order, at the full pipeline depth after it is taken
// the depth is set mostly by the two 16-stage divider pipelines per lane
// busy stays low, csr_ready stays high; the receiver cannot stall
// synchronous reset restores the gain and contrast registers and clears the valid line
`timescale 1ns / 1ps

module source_mask_balance_contrast_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [smbc_pkg::MASK_W-1:0] req_mask_vocal,
   input  logic signed [smbc_pkg::MASK_W-1:0] req_mask_bass,
   input  logic signed [smbc_pkg::MASK_W-1:0] req_mask_drum,
   input  logic signed [smbc_pkg::MASK_W-1:0] req_mask_other,
   output logic                               rsp_valid,
   output logic [smbc_pkg::Q_W-1:0]           rsp_out_vocal,
   output logic [smbc_pkg::Q_W-1:0]           rsp_out_bass,
   output logic [smbc_pkg::Q_W-1:0]           rsp_out_drum,
   output logic [smbc_pkg::Q_W-1:0]           rsp_out_other,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smbc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import smbc_pkg::*;

   logic [GAIN_W-1:0]     gain_ff [LANES];
   logic [CONTRAST_W-1:0] contrast_ff;
   logic [GQ_W-1:0]       gq;
   logic                  accept;
   logic [LATENCY-1:0]    vld_ff;
   logic [MASK_W-1:0]     mask [LANES];
   logic [SCALED_W-1:0]   scaled_ff [LANES];
   logic [SCALED_W-1:0]   scaled2_ff [LANES];
   logic [DIV_W-1:0]      sum_ff;
   logic [Q_W-1:0]        norm [LANES];
   logic [Q_W-1:0]        norm_ff [LANES];
   logic [Q_W-1:0]        min_s, max_s, min_ff, max_ff;
   logic [Q_W-1:0]        t_val [LANES];
   logic [Q_W-1:0]        pow [LANES];
   logic [Q_W-1:0]        dly_norm_ff [DLY_STAGES][LANES];
   logic [Q_W-1:0]        dly_max_ff [DLY_STAGES];
   logic                  dly_pass_ff [DLY_STAGES];
   logic [Q_W-1:0]        res_ff [LANES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) gain_ff[i] <= ONE_Q15;
         contrast_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VOCAL_GAIN: gain_ff[0]  <= csr_data;
            CSR_BASS_GAIN:  gain_ff[1]  <= csr_data;
            CSR_DRUM_GAIN:  gain_ff[2]  <= csr_data;
            CSR_OTHER_GAIN: gain_ff[3]  <= csr_data;
            CSR_CONTRAST:   contrast_ff <= csr_data[CONTRAST_W-1:0];
            default: ;
         endcase
      end
   end

   assign gq = GQ_UNITY + GQ_W'(contrast_ff) * GQ_W'(9);

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], accept};
      end
   end

   assign mask[0] = req_mask_vocal;
   assign mask[1] = req_mask_bass;
   assign mask[2] = req_mask_drum;
   assign mask[3] = req_mask_other;

   // clip and scale
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         scaled_ff[i] <= mask[i][MASK_W-1] ? '0
                        : SCALED_W'(mask[i][MASK_W-2:0]) * SCALED_W'(gain_ff[i]);
      end
   end

   // sum of the four lanes
   always_ff @(posedge clock) begin
      sum_ff <= DIV_W'(scaled_ff[0]) + DIV_W'(scaled_ff[1])
              + DIV_W'(scaled_ff[2]) + DIV_W'(scaled_ff[3]);
      for (int i = 0; i < LANES; i++) scaled2_ff[i] <= scaled_ff[i];
   end

   // normalizing dividers
   for (genvar i = 0; i < LANES; i++) begin : g_norm
      smbc_div u_div (
         .clock (clock),
         .num   (DIV_W'(scaled2_ff[i])),
         .den   (sum_ff),
         .quo   (norm[i])
      );
   end

   // merge: min and max over lanes
   always_comb begin
      min_s = norm[0];
      max_s = norm[0];
      for (int i = 1; i < LANES; i++) begin
         if (norm[i] < min_s) min_s = norm[i];
         if (norm[i] > max_s) max_s = norm[i];
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_s;
      max_ff <= max_s;
      for (int i = 0; i < LANES; i++) norm_ff[i] <= norm[i];
   end

   // contrast lanes: range divider then power
   for (genvar i = 0; i < LANES; i++) begin : g_con
      smbc_div u_div (
         .clock (clock),
         .num   (DIV_W'(norm_ff[i] - min_ff)),
         .den   (DIV_W'(max_ff - min_ff)),
         .quo   (t_val[i])
      );
      smbc_pow u_pow (
         .clock   (clock),
         .t_val   (t_val[i]),
         .gq      (gq),
         .pow_out (pow[i])
      );
   end

   // side data alongside the contrast lanes
   always_ff @(posedge clock) begin
      dly_max_ff[0]  <= max_ff;
      dly_pass_ff[0] <= (max_ff == min_ff);
      for (int i = 0; i < LANES; i++) dly_norm_ff[0][i] <= norm_ff[i];
      for (int s = 1; s < DLY_STAGES; s++) begin
         dly_max_ff[s]  <= dly_max_ff[s-1];
         dly_pass_ff[s] <= dly_pass_ff[s-1];
         for (int i = 0; i < LANES; i++) dly_norm_ff[s][i] <= dly_norm_ff[s-1][i];
      end
   end

   // rescale by max, pick the pass-through case and clamp to one
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         logic [2*Q_W-1:0] prod;
         logic [Q_W-1:0]   val;
         prod = (2*Q_W)'(pow[i]) * (2*Q_W)'(dly_max_ff[DLY_STAGES-1]);
         val  = dly_pass_ff[DLY_STAGES-1] ? dly_norm_ff[DLY_STAGES-1][i]
                                          : prod[15 +: Q_W];
         res_ff[i] <= (val > ONE_Q15) ? ONE_Q15 : val;
      end
   end

   assign rsp_valid     = vld_ff[LATENCY-1];
   assign rsp_out_vocal = res_ff[0];
   assign rsp_out_bass  = res_ff[1];
   assign rsp_out_drum  = res_ff[2];
   assign rsp_out_other = res_ff[3];

   // a taken bin appears exactly at the pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY) vld_ff[LATENCY-1])
      else $error("bin lost in pipeline");

   // no strobe without a bin in the last stage before it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[LATENCY-2] |=> !rsp_valid)
      else $error("result without bin");

   // results never exceed one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_vocal <= ONE_Q15) && (rsp_out_bass <= ONE_Q15)
                 && (rsp_out_drum <= ONE_Q15) && (rsp_out_other <= ONE_Q15))
      else $error("mask above one");

endmodule

[design/smbc_div.sv]
// pipelined restoring divider lane, one quotient bit per stage
// gives floor(num * 2^15 / den) for num <= den, zero when den is zero
// depends on smbc_pkg
`timescale 1ns / 1ps

module smbc_div (
   input  logic                        clock,
   input  logic [smbc_pkg::DIV_W-1:0]  num,
   input  logic [smbc_pkg::DIV_W-1:0]  den,
   output logic [smbc_pkg::Q_W-1:0]    quo
);
   import smbc_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_W-1:0] den_ff [DIV_STAGES];
   logic [Q_W-1:0]   quo_ff [DIV_STAGES];

   // stage zero: top quotient bit straight from the inputs
   always_ff @(posedge clock) begin
      if ({1'b0, num} >= {1'b0, den}) begin
         rem_ff[0] <= num - den;
         quo_ff[0] <= ONE_Q15;
      end else begin
         rem_ff[0] <= num;
         quo_ff[0] <= '0;
      end
      den_ff[0] <= den;
   end

   // remaining stages: shift, compare, subtract
   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
      logic [DIV_W:0] trial;
      assign trial = {rem_ff[s-1], 1'b0};
      always_ff @(posedge clock) begin
         if (trial >= {1'b0, den_ff[s-1]}) begin
            rem_ff[s] <= DIV_W'(trial - {1'b0, den_ff[s-1]});
            quo_ff[s] <= quo_ff[s-1] | (ONE_Q15 >> s);
         end else begin
            rem_ff[s] <= trial[DIV_W-1:0];
            quo_ff[s] <= quo_ff[s-1];
         end
         den_ff[s] <= den_ff[s-1];
      end
   end

   assign quo = (den_ff[DIV_STAGES-1] == '0) ? '0 : quo_ff[DIV_STAGES-1];

endmodule

[design/smbc_pow.sv]
// contrast power lane: t^gamma in q1.15 through log2 and exp2 tables
// four register stages; depends on smbc_pkg
`timescale 1ns / 1ps

module smbc_pow (
   input  logic                       clock,
   input  logic [smbc_pkg::Q_W-1:0]   t_val,
   input  logic [smbc_pkg::GQ_W-1:0]  gq,
   output logic [smbc_pkg::Q_W-1:0]   pow_out
);
   import smbc_pkg::*;

   logic [3:0]                k_s;
   logic [Q_W-1:0]            norm_s;
   logic [Q_W-1:0]            t1_ff, t2_ff, t3_ff;
   logic [3:0]                k1_ff;
   logic [LOG_TABLE_BITS-1:0] idx1_ff;
   logic [NEG_W-1:0]          neg2_ff;
   logic [EXP_W-1:0]          e3_ff;
   logic [NEG_W+GQ_W-1:0]     prod_s;
   logic [8:0]                ip_s;
   logic [LOG_TABLE_BITS-1:0] j_s;
   logic [Q_W-1:0]            p_s;
   logic [Q_W-1:0]            pow_ff;

   // leading one position
   always_comb begin
      k_s = '0;
      for (int b = 1; b < 15; b++) begin
         if (t_val[b]) k_s = 4'(b);
      end
   end
   assign norm_s = Q_W'(t_val << (4'd15 - k_s));

   // stage one: exponent and table index
   always_ff @(posedge clock) begin
      t1_ff   <= t_val;
      k1_ff   <= k_s;
      idx1_ff <= norm_s[14 -: LOG_TABLE_BITS];
   end

   // stage two: negated log2
   always_ff @(posedge clock) begin
      t2_ff   <= t1_ff;
      neg2_ff <= NEG_W'({4'd15 - k1_ff, 16'd0}) - NEG_W'(LG_TABLE[idx1_ff]);
   end

   // stage three: scale by gamma
   assign prod_s = NEG_W'(neg2_ff) * (NEG_W+GQ_W)'(gq);
   always_ff @(posedge clock) begin
      t3_ff <= t2_ff;
      e3_ff <= prod_s[8 +: EXP_W];
   end

   // stage four: exp2 and the fixed special cases
   assign ip_s = e3_ff[EXP_W-1:16];
   assign j_s  = e3_ff[15 -: LOG_TABLE_BITS];
   always_comb begin
      if (t3_ff == '0) begin
         p_s = '0;
      end else if (t3_ff[15]) begin
         p_s = ONE_Q15;
      end else if (gq == GQ_UNITY) begin
         p_s = t3_ff;
      end else if (ip_s > 9'd15) begin
         p_s = '0;
      end else begin
         p_s = Q_W'(EX_TABLE[j_s] >> (15 + ip_s[3:0]));
      end
   end

   always_ff @(posedge clock) begin
      pow_ff <= p_s;
   end

   assign pow_out = pow_ff;

endmodule
